FILE: sv/ebrq_pkg.sv
// Shared types, codes and helpers of the event byte ring queue.
package ebrq_pkg;

   localparam int unsigned COUNT_W  = 5;
   localparam int unsigned EVENT_W  = 96;

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   typedef struct packed {
      logic [7:0]         event_byte;
      logic               byte_valid;
      logic               last;
      logic               push_accepted;
      logic               is_full;
      logic               is_empty;
      logic [COUNT_W-1:0] event_count;
   } rsp_type;

   function automatic logic [7:0] byte_at(input logic [EVENT_W-1:0] ev,
                                          input logic [3:0] k);
      logic [EVENT_W-1:0] sh;
      sh = ev << {k, 3'b000};
      return sh[EVENT_W-1 -: 8];
   endfunction

endpackage

FILE: sv/ebrq_if.sv
// Request and response channel interfaces of the event byte ring queue.
interface ebrq_req_if;
   logic               valid;
   logic               ready;
   logic               func;
   logic [31:0]        timestamp;
   logic signed [15:0] data_word_0;
   logic signed [15:0] data_word_1;
   logic signed [15:0] data_word_2;
   logic signed [15:0] data_word_3;

   modport source (output valid, func, timestamp, data_word_0, data_word_1,
                   data_word_2, data_word_3, input ready);
   modport sink (input valid, func, timestamp, data_word_0, data_word_1,
                 data_word_2, data_word_3, output ready);
endinterface

interface ebrq_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  event_byte;
   logic        byte_valid;
   logic        last;
   logic        push_accepted;
   logic        is_full;
   logic        is_empty;
   logic [4:0]  event_count;

   modport source (output valid, event_byte, byte_valid, last, push_accepted,
                   is_full, is_empty, event_count, input ready);
   modport sink (input valid, event_byte, byte_valid, last, push_accepted,
                 is_full, is_empty, event_count, output ready);
endinterface

FILE: sv/ebrq_ram.sv
// Byte-wide ring memory, one write and one registered read port.
module ebrq_ram #(
   parameter int unsigned DEPTH  = 192,
   parameter int unsigned ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/ebrq_ctrl.sv
// Sequencer: pointers, event count, byte write and read-out pipeline.
module ebrq_ctrl #(
   parameter int unsigned EVENT_WORDS = 4,
   parameter int unsigned EVENT_SLOTS = 16,
   parameter int unsigned PTR_W       = 8
) (
   input  logic               clock,
   input  logic               reset,
   ebrq_req_if.sink           req,
   input  logic               out_free,
   output logic               ld,
   output ebrq_pkg::rsp_type  ld_data,
   output logic               wr_en,
   output logic [PTR_W-1:0]   wr_addr,
   output logic [7:0]         wr_data,
   output logic               rd_en,
   output logic [PTR_W-1:0]   rd_addr,
   input  logic [7:0]         rd_data
);

   localparam int unsigned EVENT_LEN = 4 + 2 * EVENT_WORDS;
   localparam int unsigned RING_LEN  = EVENT_SLOTS * EVENT_LEN;
   localparam int unsigned IDX_W     = $clog2(EVENT_LEN);
   localparam int unsigned CW        = ebrq_pkg::COUNT_W;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_PUSH = 4'b0010,
      ST_POP  = 4'b0100,
      ST_RESP = 4'b1000
   } state_type;

   state_type                   state_ff, state_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [PTR_W-1:0]            wp_ff, wp_in, rp_ff, rp_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic                        iss_done_ff, iss_done_in;
   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_last_ff, s1_last_in;
   logic [ebrq_pkg::EVENT_W-1:0] ev_ff, ev_in;
   ebrq_pkg::rsp_type           resp_ff, resp_in;

   logic accept, full, empty, idx_last, s1_adv;

   assign full     = (count_ff == CW'(EVENT_SLOTS));
   assign empty    = (count_ff == '0);
   assign idx_last = (idx_ff == IDX_W'(EVENT_LEN - 1));
   assign s1_adv   = s1_valid_ff && out_free;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;

   assign wr_en   = (state_ff == ST_PUSH);
   assign wr_addr = wp_ff;
   assign wr_data = ebrq_pkg::byte_at(ev_ff, 4'(idx_ff));
   assign rd_en   = (state_ff == ST_POP) && !iss_done_ff && (!s1_valid_ff || s1_adv);
   assign rd_addr = rp_ff;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      wp_in       = wp_ff;
      rp_in       = rp_ff;
      idx_in      = idx_ff;
      iss_done_in = iss_done_ff;
      s1_valid_in = s1_valid_ff;
      s1_last_in  = s1_last_ff;
      ev_in       = ev_ff;
      resp_in     = resp_ff;
      ld          = 1'b0;
      ld_data     = resp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               resp_in = '{event_byte: 8'h00, byte_valid: 1'b0, last: 1'b1,
                           push_accepted: 1'b0, is_full: full, is_empty: empty,
                           event_count: count_ff};
               idx_in      = '0;
               iss_done_in = 1'b0;
               if (req.func == ebrq_pkg::FUNC_PUSH) begin
                  if (full) begin
                     state_in = ST_RESP;
                  end else begin
                     ev_in    = {req.timestamp, req.data_word_0, req.data_word_1,
                                 req.data_word_2, req.data_word_3};
                     count_in = count_ff + CW'(1);
                     state_in = ST_PUSH;
                  end
               end else begin
                  if (empty) begin
                     state_in = ST_RESP;
                  end else begin
                     count_in = count_ff - CW'(1);
                     state_in = ST_POP;
                  end
               end
            end
         end
         ST_PUSH: begin
            wp_in  = (wp_ff == PTR_W'(RING_LEN - 1)) ? '0 : wp_ff + PTR_W'(1);
            idx_in = idx_ff + IDX_W'(1);
            if (idx_last) begin
               resp_in = '{event_byte: 8'h00, byte_valid: 1'b0, last: 1'b1,
                           push_accepted: 1'b1, is_full: full, is_empty: empty,
                           event_count: count_ff};
               state_in = ST_RESP;
            end
         end
         ST_POP: begin
            ld      = s1_adv;
            ld_data = '{event_byte: rd_data, byte_valid: 1'b1, last: s1_last_ff,
                        push_accepted: 1'b0, is_full: full, is_empty: empty,
                        event_count: count_ff};
            if (rd_en) begin
               rp_in       = (rp_ff == PTR_W'(RING_LEN - 1)) ? '0 : rp_ff + PTR_W'(1);
               idx_in      = idx_ff + IDX_W'(1);
               iss_done_in = idx_last;
               s1_valid_in = 1'b1;
               s1_last_in  = idx_last;
            end else if (s1_adv) begin
               s1_valid_in = 1'b0;
            end
            if (s1_adv && s1_last_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_RESP: begin
            ld = out_free;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         wp_ff       <= '0;
         rp_ff       <= '0;
         idx_ff      <= '0;
         iss_done_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s1_last_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         wp_ff       <= wp_in;
         rp_ff       <= rp_in;
         idx_ff      <= idx_in;
         iss_done_ff <= iss_done_in;
         s1_valid_ff <= s1_valid_in;
         s1_last_ff  <= s1_last_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_ff   <= ev_in;
      resp_ff <= resp_in;
   end

endmodule

FILE: sv/event_byte_ring_queue_unit.sv
// Top level of the event byte ring queue: sequencer, ring memory, output stage.
//
// req_chan carries one operation per transfer: func selects push (store the
// timestamp and the first EVENT_WORDS data words as 4 + 2*EVENT_WORDS bytes)
// or pop (read out the oldest event). rsp_chan returns the results in order.
// A push, or any dropped push or pop of an empty queue, gives one result.
// A successful pop gives one result per stored byte, the final one marked
// with last; every result carries the full and empty flags and event count.
// Throughput: a push writes its 4 + 2*EVENT_WORDS bytes to the ring memory
// one byte per cycle, then hands its result to the output register. A pop
// reads one byte per cycle through the single read port unless rsp_chan
// stalls; each byte goes via the memory read register and output register.
// Items are taken one at a time; req_chan is ready again once the previous
// item's last result sits in the output register.
// When rsp_chan stalls, the output register and the memory read register
// hold their bytes and further reads wait.
// Reset empties the queue at once; stored bytes are not cleared.
module event_byte_ring_queue_unit #(
   parameter int unsigned EVENT_WORDS = 4,
   parameter int unsigned EVENT_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   ebrq_req_if.sink    req_chan,
   ebrq_rsp_if.source  rsp_chan
);

   localparam int unsigned EVENT_LEN = 4 + 2 * EVENT_WORDS;
   localparam int unsigned RING_LEN  = EVENT_SLOTS * EVENT_LEN;
   localparam int unsigned PTR_W     = $clog2(RING_LEN);

   logic              out_valid_ff, out_valid_in;
   ebrq_pkg::rsp_type out_data_ff, out_data_in;
   logic              out_free, ld;
   ebrq_pkg::rsp_type ld_data;
   logic              wr_en, rd_en;
   logic [PTR_W-1:0]  wr_addr, rd_addr;
   logic [7:0]        wr_data, rd_data;

   ebrq_ctrl #(
      .EVENT_WORDS (EVENT_WORDS),
      .EVENT_SLOTS (EVENT_SLOTS),
      .PTR_W       (PTR_W)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .out_free (out_free),
      .ld       (ld),
      .ld_data  (ld_data),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data)
   );

   ebrq_ram #(
      .DEPTH  (RING_LEN),
      .ADDR_W (PTR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (ld) begin
         out_valid_in = 1'b1;
         out_data_in  = ld_data;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.event_byte    = out_data_ff.event_byte;
   assign rsp_chan.byte_valid    = out_data_ff.byte_valid;
   assign rsp_chan.last          = out_data_ff.last;
   assign rsp_chan.push_accepted = out_data_ff.push_accepted;
   assign rsp_chan.is_full       = out_data_ff.is_full;
   assign rsp_chan.is_empty      = out_data_ff.is_empty;
   assign rsp_chan.event_count   = out_data_ff.event_count;

endmodule

FILE: sv/ebrq_checker.sv
// Port-level assertions of the event byte ring queue and their binding.
module ebrq_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] event_byte,
   input logic       byte_valid,
   input logic       last,
   input logic       push_accepted,
   input logic       is_full,
   input logic       is_empty,
   input logic [4:0] event_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(event_byte) && $stable(last)
         && $stable(byte_valid) && $stable(event_count))
      else $error("response changed while stalled");

   a_no_data_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !byte_valid |-> last && (event_byte == 8'h00))
      else $error("result without data is not a single zero result");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(is_full && is_empty))
      else $error("queue reported full and empty");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (is_empty == (event_count == 5'd0)))
      else $error("empty flag disagrees with event count");

   a_push_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && push_accepted |-> !byte_valid && !is_empty)
      else $error("stored push reported with data or empty queue");

endmodule

bind event_byte_ring_queue_unit ebrq_checker u_ebrq_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .event_byte    (rsp_chan.event_byte),
   .byte_valid    (rsp_chan.byte_valid),
   .last          (rsp_chan.last),
   .push_accepted (rsp_chan.push_accepted),
   .is_full       (rsp_chan.is_full),
   .is_empty      (rsp_chan.is_empty),
   .event_count   (rsp_chan.event_count)
);

FILE: tb/testbench.sv
// Self-checking testbench of the event byte ring queue with its scoreboard.
`timescale 1ns / 100ps

module testbench;

   localparam int unsigned EVENT_WORDS = 4;
   localparam int unsigned EVENT_SLOTS = 16;
   localparam int unsigned EVENT_BYTES = 4 + 2 * EVENT_WORDS;
   localparam int unsigned RING_BYTES  = EVENT_SLOTS * EVENT_BYTES;
   localparam int unsigned RANDOM_OPS  = 300;

   class ring_queue_scoreboard;
      logic [7:0] ring [RING_BYTES];
      int unsigned wr_ptr;
      int unsigned rd_ptr;
      bit full;
      bit empty;
      int unsigned count;
      ebrq_pkg::rsp_type expected_rsps [$];
      int unsigned mismatches;

      function new();
         wr_ptr = 0;
         rd_ptr = 0;
         full = 1'b0;
         empty = 1'b1;
         count = 0;
         mismatches = 0;
      endfunction

      function int unsigned next_ptr(input int unsigned p);
         return (p + 1 >= RING_BYTES) ? 0 : p + 1;
      endfunction

      function void put_byte(input logic [7:0] b);
         ring[wr_ptr] = b;
         wr_ptr = next_ptr(wr_ptr);
      endfunction

      function void add_rsp(input logic [7:0] b, input logic bv, input logic lst,
                            input logic acc);
         ebrq_pkg::rsp_type r;
         r.event_byte    = b;
         r.byte_valid    = bv;
         r.last          = lst;
         r.push_accepted = acc;
         r.is_full       = full;
         r.is_empty      = empty;
         r.event_count   = count[ebrq_pkg::COUNT_W-1:0];
         expected_rsps.push_back(r);
      endfunction

      function void note_request(input logic func, input logic [31:0] ts,
                                 input logic [15:0] w0, input logic [15:0] w1,
                                 input logic [15:0] w2, input logic [15:0] w3);
         logic [15:0] words [4];
         int unsigned p;
         words[0] = w0;
         words[1] = w1;
         words[2] = w2;
         words[3] = w3;
         if (func == ebrq_pkg::FUNC_PUSH) begin
            if (full) begin
               add_rsp(8'h00, 1'b0, 1'b1, 1'b0);
               return;
            end
            for (int i = 0; i < 4; i++) put_byte(ts[31 - 8 * i -: 8]);
            for (int i = 0; i < EVENT_WORDS; i++) begin
               put_byte(words[i][15:8]);
               put_byte(words[i][7:0]);
            end
            empty = 1'b0;
            if (count < 31) count++;
            full = (wr_ptr == rd_ptr);
            add_rsp(8'h00, 1'b0, 1'b1, 1'b1);
         end else begin
            if (empty) begin
               add_rsp(8'h00, 1'b0, 1'b1, 1'b0);
               return;
            end
            p = rd_ptr;
            full = 1'b0;
            if (count > 0) count--;
            for (int i = 0; i < EVENT_BYTES; i++) rd_ptr = next_ptr(rd_ptr);
            empty = (wr_ptr == rd_ptr);
            for (int i = 0; i < EVENT_BYTES; i++) begin
               add_rsp(ring[p], 1'b1, (i == EVENT_BYTES - 1), 1'b0);
               p = next_ptr(p);
            end
         end
      endfunction

      function void check_rsp(input ebrq_pkg::rsp_type got);
         ebrq_pkg::rsp_type exp;
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected byte %02h bv %0b last %0b acc %0b full %0b empty %0b cnt %0d",
                        got.event_byte, got.byte_valid, got.last, got.push_accepted,
                        got.is_full, got.is_empty, got.event_count);
            return;
         end
         exp = expected_rsps.pop_front();
         if (got.event_byte !== exp.event_byte || got.byte_valid !== exp.byte_valid ||
             got.last !== exp.last || got.push_accepted !== exp.push_accepted ||
             got.is_full !== exp.is_full || got.is_empty !== exp.is_empty ||
             got.event_count !== exp.event_count) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("expected: byte %02h bv %0b last %0b acc %0b full %0b empty %0b cnt %0d",
                        exp.event_byte, exp.byte_valid, exp.last, exp.push_accepted,
                        exp.is_full, exp.is_empty, exp.event_count);
               $display("actual:   byte %02h bv %0b last %0b acc %0b full %0b empty %0b cnt %0d",
                        got.event_byte, got.byte_valid, got.last, got.push_accepted,
                        got.is_full, got.is_empty, got.event_count);
            end
         end
      endfunction

      function int unsigned pending();
         return expected_rsps.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   ring_queue_scoreboard scoreboard;

   ebrq_req_if req_chan ();
   ebrq_rsp_if rsp_chan ();

   event_byte_ring_queue_unit #(
      .EVENT_WORDS (EVENT_WORDS),
      .EVENT_SLOTS (EVENT_SLOTS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   initial begin
      recv_stall_pct = 0;
      rsp_chan.ready = 1'b0;
   end

   always @(negedge clock) begin
      rsp_chan.ready = ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      ebrq_pkg::rsp_type got;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got.event_byte    = rsp_chan.event_byte;
         got.byte_valid    = rsp_chan.byte_valid;
         got.last          = rsp_chan.last;
         got.push_accepted = rsp_chan.push_accepted;
         got.is_full       = rsp_chan.is_full;
         got.is_empty      = rsp_chan.is_empty;
         got.event_count   = rsp_chan.event_count;
         scoreboard.check_rsp(got);
      end
   end

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'hffff;
         3: return 16'h0000;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [31:0] pick_stamp();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_op(input logic func, input logic [31:0] ts,
                          input logic [15:0] w0, input logic [15:0] w1,
                          input logic [15:0] w2, input logic [15:0] w3);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.func        = func;
      req_chan.timestamp   = ts;
      req_chan.data_word_0 = w0;
      req_chan.data_word_1 = w1;
      req_chan.data_word_2 = w2;
      req_chan.data_word_3 = w3;
      req_chan.valid       = 1'b1;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      scoreboard.note_request(func, ts, w0, w1, w2, w3);
   endtask

   task automatic send_random(input logic func);
      send_op(func, pick_stamp(), pick_word(), pick_word(), pick_word(), pick_word());
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (scoreboard.pending() != 0) @(posedge clock);
   endtask

   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int unsigned produced;
      int unsigned kind;
      int unsigned run_len;
      int unsigned push_pct;
      int unsigned phase;
      int unsigned last_phase;
      logic func;

      scoreboard = new();
      send_idle_pct = 0;
      req_chan.valid       = 1'b0;
      req_chan.func        = ebrq_pkg::FUNC_PUSH;
      req_chan.timestamp   = '0;
      req_chan.data_word_0 = '0;
      req_chan.data_word_1 = '0;
      req_chan.data_word_2 = '0;
      req_chan.data_word_3 = '0;
      reset = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_op(ebrq_pkg::FUNC_POP, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0);
      send_op(ebrq_pkg::FUNC_PUSH, 32'h0000_0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_op(ebrq_pkg::FUNC_PUSH, 32'hffff_ffff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      send_op(ebrq_pkg::FUNC_PUSH, 32'h0123_4567, 16'hffff, 16'h0000, 16'h8001, 16'h7ffe);
      send_op(ebrq_pkg::FUNC_PUSH, 32'h89ab_cdef, 16'h5a5a, 16'ha5a5, 16'h0001, 16'hfffe);
      repeat (4) send_op(ebrq_pkg::FUNC_POP, $urandom, pick_word(), pick_word(),
                         pick_word(), pick_word());
      send_op(ebrq_pkg::FUNC_POP, 32'hffff_ffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
      wait_drained();

      produced = 0;
      last_phase = 0;
      repeat (EVENT_SLOTS + 2) begin
         send_random(ebrq_pkg::FUNC_PUSH);
         produced++;
      end
      while (produced < RANDOM_OPS) begin
         kind = $urandom_range(0, 4);
         run_len = $urandom_range(4, 24);
         push_pct = (kind < 2) ? 85 : (kind < 4) ? 15 : 50;
         repeat (run_len) begin
            phase = (produced * 4) / RANDOM_OPS;
            if (phase > 3) phase = 3;
            if (phase != last_phase) begin
               wait_drained();
               last_phase = phase;
               case (phase)
                  1: begin send_idle_pct = 82; recv_stall_pct = 0; end
                  2: begin send_idle_pct = 0; recv_stall_pct = 82; end
                  default: begin send_idle_pct = 32; recv_stall_pct = 32; end
               endcase
            end
            func = ($urandom_range(99) < push_pct) ? ebrq_pkg::FUNC_PUSH
                                                   : ebrq_pkg::FUNC_POP;
            send_random(func);
            produced++;
         end
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (scoreboard.mismatches == 0 && scoreboard.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: event_byte_ring_queue_unit.f
sv/ebrq_pkg.sv
sv/ebrq_if.sv
sv/ebrq_ram.sv
sv/ebrq_ctrl.sv
sv/event_byte_ring_queue_unit.sv
sv/ebrq_checker.sv
tb/testbench.sv
